/* sv/battery_level_debounced_gauge_macros.svh */
// Assertion macros shared by the gauge modules.
// Each macro expects the module to have a clock named clk and a reset named rst.
`ifndef BATTERY_LEVEL_DEBOUNCED_GAUGE_MACROS_SVH
`define BATTERY_LEVEL_DEBOUNCED_GAUGE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BLDG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BLDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/bldg_pkg.sv */
// Shared types and constants for the battery level gauge.
// Used by the controller, the datapath, the divider and the top level.
package bldg_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MV_W     = 13;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned DIVD_W   = 20;
  localparam int unsigned DIVR_W   = 13;
  localparam int unsigned BITS_W   = 5;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 32;

  localparam logic [MV_W-1:0]     MV_FULL  = 13'd6600;
  localparam logic [SAMPLE_W-1:0] ADC_FULL = 12'd4095;
  localparam logic [PCT_W-1:0]    PCT_FULL = 7'd100;

  // Quotient bits of the percent division.
  localparam logic [BITS_W-1:0] PCT_BITS = 5'd20;

  // The window mean and the millivolt scaling are reciprocal products. The shifts are
  // large enough that both truncate exactly over their whole input ranges.
  localparam int unsigned AVG_SHIFT   = 20;
  localparam int unsigned AVG_RECIP_W = 21;
  localparam int unsigned MV_SHIFT    = 24;
  localparam int unsigned MV_RECIP_W  = 25;
  localparam logic [MV_RECIP_W-1:0] MV_RECIP =
    MV_RECIP_W'((64'(MV_FULL) << MV_SHIFT) / 64'(ADC_FULL) + 64'd1);

  localparam logic [MV_W-1:0]   MIN_MV_RST = 13'd3100;
  localparam logic [MV_W-1:0]   MAX_MV_RST = 13'd4100;
  localparam logic [HOLD_W-1:0] HOLD_RST   = 8'd100;

  localparam logic [IDX_W-1:0] REG_MIN_MV = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_MV = 2'd1;
  localparam logic [IDX_W-1:0] REG_HOLD   = 2'd2;

  typedef enum logic [1:0] {
    OP_AVG,
    OP_MV,
    OP_PCT
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MV,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_PUBLISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_PUBLISH,
    PH_STEADY,
    PH_COUNT,
    PH_ADOPT
  } phase_t;

  typedef struct packed {
    logic    accept;
    logic    div_start;
    div_op_t op;
    logic    capture;
    logic    pct_zero;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic span_empty;
    logic out_free;
  } dp_sts_t;

endpackage

/* sv/bldg_div.sv */
// Restoring divider for the percent, one quotient bit per cycle.
// Depends on bldg_pkg for widths.
module bldg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bldg_pkg::DIVD_W-1:0]  dividend,
  input  logic [bldg_pkg::DIVR_W-1:0]  divisor,
  input  logic [bldg_pkg::BITS_W-1:0]  bits,
  output logic                         busy,
  output logic [bldg_pkg::DIVD_W-1:0]  quotient
);

  logic [bldg_pkg::DIVR_W-1:0] rem;
  logic [bldg_pkg::DIVR_W-1:0] divr;
  logic [bldg_pkg::DIVD_W-1:0] quo;
  logic [bldg_pkg::BITS_W-1:0] cnt;
  logic [bldg_pkg::BITS_W-1:0] shift_amt;
  logic [bldg_pkg::DIVR_W:0]   shifted;
  logic                        fits;

  assign shift_amt = bldg_pkg::BITS_W'(bldg_pkg::DIVD_W) - bits;
  assign shifted   = {rem, quo[bldg_pkg::DIVD_W-1]};
  assign fits      = shifted >= {1'b0, divr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= bits;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == bldg_pkg::BITS_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The dividend is left-aligned so that only the wanted quotient bits are produced.
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend << shift_amt;
      rem  <= '0;
      divr <= divisor;
    end else if (busy) begin
      quo <= {quo[bldg_pkg::DIVD_W-2:0], fits};
      if (fits) begin
        rem <= bldg_pkg::DIVR_W'(shifted - {1'b0, divr});
      end else begin
        rem <= shifted[bldg_pkg::DIVR_W-1:0];
      end
    end
  end

endmodule

/* sv/bldg_dp.sv */
// Datapath: sample window, configuration registers, mean and millivolt products,
// percent division, debounce and result register.
// Depends on bldg_pkg, bldg_div and the assertion macro header.
`include "battery_level_debounced_gauge_macros.svh"

module bldg_dp #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bldg_pkg::dp_cmd_t              cmd,
  output bldg_pkg::dp_sts_t              sts,
  input  logic [bldg_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           cfg_we,
  input  logic [bldg_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bldg_pkg::MV_W-1:0]      cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [bldg_pkg::OUT_W-1:0]     out_data
);

  localparam int unsigned SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned AVG_PROD_W = bldg_pkg::TOTAL_W + bldg_pkg::AVG_RECIP_W;
  localparam int unsigned MV_PROD_W  = bldg_pkg::SAMPLE_W + bldg_pkg::MV_RECIP_W;
  localparam logic [bldg_pkg::AVG_RECIP_W-1:0] AVG_RECIP =
    bldg_pkg::AVG_RECIP_W'((64'd1 << bldg_pkg::AVG_SHIFT) / 64'(WINDOW) + 64'd1);

  logic [bldg_pkg::MV_W-1:0]   min_mv;
  logic [bldg_pkg::MV_W-1:0]   max_mv;
  logic [bldg_pkg::HOLD_W-1:0] hold_count;

  logic [bldg_pkg::SAMPLE_W-1:0] win [WINDOW];
  logic [SLOT_W-1:0]             slot;
  logic [bldg_pkg::TOTAL_W-1:0]  total;
  logic                          primed;

  logic [bldg_pkg::SAMPLE_W-1:0] avg;
  logic [bldg_pkg::MV_W-1:0]     mv;
  logic [bldg_pkg::PCT_W-1:0]    pct;

  logic [AVG_PROD_W-1:0]         avg_prod;
  logic [MV_PROD_W-1:0]          mv_prod;
  logic [bldg_pkg::SAMPLE_W-1:0] avg_calc;
  logic [bldg_pkg::MV_W-1:0]     mv_calc;

  bldg_pkg::phase_t             phase;
  bldg_pkg::phase_t             phase_next;
  logic [bldg_pkg::HOLD_W-1:0]  dcount;
  logic [bldg_pkg::HOLD_W-1:0]  dcount_next;
  logic [bldg_pkg::PCT_W-1:0]   level;
  logic [bldg_pkg::PCT_W-1:0]   level_next;

  logic [bldg_pkg::DIVD_W-1:0]   dividend;
  logic [bldg_pkg::DIVR_W-1:0]   divisor;
  logic [bldg_pkg::BITS_W-1:0]   bits;
  logic [bldg_pkg::DIVD_W-1:0]   quotient;
  logic                          div_busy;
  logic [bldg_pkg::MV_W-1:0]     clamped;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_mv     <= bldg_pkg::MIN_MV_RST;
      max_mv     <= bldg_pkg::MAX_MV_RST;
      hold_count <= bldg_pkg::HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bldg_pkg::REG_MIN_MV: min_mv     <= cfg_data;
        bldg_pkg::REG_MAX_MV: max_mv     <= cfg_data;
        bldg_pkg::REG_HOLD:   hold_count <= cfg_data[bldg_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Moving-average window. The first sample after reset fills every entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      slot   <= '0;
    end else if (cmd.accept) begin
      primed <= 1'b1;
      if (!primed) begin
        slot <= (WINDOW > 1) ? SLOT_W'(1) : '0;
      end else if (slot == SLOT_W'(WINDOW - 1)) begin
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (!primed) begin
        for (int i = 0; i < WINDOW; i++) begin
          win[i] <= sample;
        end
        total <= bldg_pkg::TOTAL_W'({4'b0, sample} * bldg_pkg::TOTAL_W'(WINDOW));
      end else begin
        win[slot] <= sample;
        total     <= bldg_pkg::TOTAL_W'(total - {4'b0, win[slot]} + {4'b0, sample});
      end
    end
  end

  // Mean and millivolts come from one reciprocal product each, in separate cycles.
  assign avg_prod = AVG_PROD_W'(total) * AVG_PROD_W'(AVG_RECIP);
  assign avg_calc = avg_prod[bldg_pkg::AVG_SHIFT +: bldg_pkg::SAMPLE_W];
  assign mv_prod  = MV_PROD_W'(avg) * MV_PROD_W'(bldg_pkg::MV_RECIP);
  assign mv_calc  = mv_prod[bldg_pkg::MV_SHIFT +: bldg_pkg::MV_W];

  // Percent operands for the divider.
  always_comb begin
    if (mv < min_mv) begin
      clamped = min_mv;
    end else if (mv > max_mv) begin
      clamped = max_mv;
    end else begin
      clamped = mv;
    end
  end

  assign dividend = bldg_pkg::DIVD_W'(clamped - min_mv) * bldg_pkg::DIVD_W'(bldg_pkg::PCT_FULL);
  assign divisor  = max_mv - min_mv;
  assign bits     = bldg_pkg::PCT_BITS;

  bldg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .bits     (bits),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.pct_zero) begin
      pct <= '0;
    end else if (cmd.capture) begin
      case (cmd.op)
        bldg_pkg::OP_AVG: avg <= avg_calc;
        bldg_pkg::OP_MV:  mv  <= mv_calc;
        bldg_pkg::OP_PCT: pct <= quotient[bldg_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Debounce of the reported percent.
  always_comb begin
    phase_next  = phase;
    dcount_next = dcount;
    level_next  = level;
    case (phase)
      bldg_pkg::PH_PUBLISH: begin
        level_next = pct;
        phase_next = bldg_pkg::PH_STEADY;
      end
      bldg_pkg::PH_STEADY: begin
        if (level != pct) begin
          dcount_next = '0;
          phase_next  = bldg_pkg::PH_COUNT;
        end
      end
      bldg_pkg::PH_COUNT: begin
        if (dcount != '1) begin
          dcount_next = dcount + 1'b1;
        end
        if (dcount_next >= hold_count) begin
          phase_next = bldg_pkg::PH_ADOPT;
        end
        if (level == pct) begin
          phase_next = bldg_pkg::PH_STEADY;
        end
      end
      default: begin
        level_next = pct;
        phase_next = bldg_pkg::PH_STEADY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= bldg_pkg::PH_PUBLISH;
      dcount <= '0;
      level  <= '0;
    end else if (cmd.out_load) begin
      phase  <= phase_next;
      dcount <= dcount_next;
      level  <= level_next;
    end
  end

  // Result register; it holds a finished beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {level_next, mv, avg};
    end
  end

  assign sts.div_busy   = div_busy;
  assign sts.span_empty = max_mv <= min_mv;
  assign sts.out_free   = !out_valid || out_ready;

  `BLDG_ASSERT_SAME(a_slot_in_range, primed, slot <= SLOT_W'(WINDOW - 1), "write slot beyond window")
  `BLDG_ASSERT_SAME(a_level_bounded, out_valid, out_data[bldg_pkg::OUT_W-1 -: bldg_pkg::PCT_W] <= bldg_pkg::PCT_FULL, "reported percent above full scale")
  `BLDG_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(out_data), "waiting beat changed")

endmodule

/* sv/bldg_ctrl.sv */
// Controller: sequences window update, mean, millivolts, the percent division and publishing.
// Depends on bldg_pkg and the assertion macro header.
`include "battery_level_debounced_gauge_macros.svh"

module bldg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bldg_pkg::dp_sts_t  sts,
  output bldg_pkg::dp_cmd_t  cmd
);

  bldg_pkg::ctrl_state_t state;
  bldg_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bldg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bldg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = bldg_pkg::ST_AVG;
        end
      end
      bldg_pkg::ST_AVG: state_next = bldg_pkg::ST_MV;
      bldg_pkg::ST_MV:  state_next = bldg_pkg::ST_PCT_GO;
      bldg_pkg::ST_PCT_GO: begin
        if (sts.span_empty) begin
          state_next = bldg_pkg::ST_PUBLISH;
        end else begin
          state_next = bldg_pkg::ST_PCT_WAIT;
        end
      end
      bldg_pkg::ST_PCT_WAIT: begin
        if (!sts.div_busy) begin
          state_next = bldg_pkg::ST_PUBLISH;
        end
      end
      bldg_pkg::ST_PUBLISH: begin
        if (sts.out_free) begin
          state_next = bldg_pkg::ST_IDLE;
        end
      end
      default: state_next = bldg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.op        = bldg_pkg::OP_AVG;
    cmd.capture   = 1'b0;
    cmd.pct_zero  = 1'b0;
    cmd.out_load  = 1'b0;
    case (state)
      bldg_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      bldg_pkg::ST_AVG: begin
        cmd.capture = 1'b1;
      end
      bldg_pkg::ST_MV: begin
        cmd.op      = bldg_pkg::OP_MV;
        cmd.capture = 1'b1;
      end
      bldg_pkg::ST_PCT_GO: begin
        cmd.op        = bldg_pkg::OP_PCT;
        cmd.pct_zero  = sts.span_empty;
        cmd.div_start = !sts.span_empty;
      end
      bldg_pkg::ST_PCT_WAIT: begin
        cmd.op      = bldg_pkg::OP_PCT;
        cmd.capture = !sts.div_busy;
      end
      bldg_pkg::ST_PUBLISH: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

  `BLDG_ASSERT_SAME(a_no_overwrite, cmd.out_load, sts.out_free, "result loaded over a waiting beat")
  `BLDG_ASSERT_NEXT(a_div_starts, cmd.div_start, sts.div_busy, "divider did not start")
  `BLDG_ASSERT_SAME(a_capture_idle, cmd.capture, !sts.div_busy, "quotient captured while dividing")

endmodule

/* sv/battery_level_debounced_gauge.sv */
// Channel   Dir  Payload (lowest bit first)
// s_axis    in   sample[11:0], zero pad to 16 bits
// m_axis    out  average_raw[11:0], voltage_mv[24:12], level_percent[31:25]
// cfg       in   cfg_index selects min_mv, max_mv or hold_count; cfg_data holds the value
//
// Each input beat is accepted, then the mean and millivolt products are captured in turn,
// the percent divider is started and run, and the result is published once the output
// register is free; an empty percent span skips the divider and gives zero percent.
// A new sample is taken once the previous result has moved into the output register.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled output holds its beat; the controller waits before overwriting it.
module battery_level_debounced_gauge #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bldg_pkg::IN_W-1:0]     s_axis_tdata,  // sample[11:0], zeros above
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bldg_pkg::OUT_W-1:0]    m_axis_tdata,  // average_raw, voltage_mv, level_percent
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bldg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bldg_pkg::MV_W-1:0]     cfg_data
);

  bldg_pkg::dp_cmd_t cmd;
  bldg_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bldg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bldg_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (s_axis_tdata[bldg_pkg::SAMPLE_W-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

/* test/battery_level_debounced_gauge_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the battery level gauge: watches the sample, result and register channels.
// Predicts average, millivolts and debounced percent per sample; needs bldg_pkg.
module battery_level_debounced_gauge_checker
  import bldg_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OUT_W-1:0]    m_axis_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [MV_W-1:0]     cfg_data,
  output int                  fail_count,
  output int                  results_checked,
  output int                  results_pending
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_raw;
    logic [MV_W-1:0]     voltage_mv;
    logic [PCT_W-1:0]    level_percent;
  } gauge_reading_t;

  // Register copies.
  logic [MV_W-1:0]     span_lo_mv;
  logic [MV_W-1:0]     span_hi_mv;
  logic [HOLD_W-1:0]   hold_items;

  // Averaging window and debounce state.
  logic [SAMPLE_W-1:0] window_samples [WINDOW];
  int unsigned         next_slot;
  logic [TOTAL_W-1:0]  window_sum;
  logic                primed;
  phase_t              debounce_phase;
  logic [HOLD_W-1:0]   differ_items;
  logic [PCT_W-1:0]    shown_percent;

  gauge_reading_t      expected_readings [$];

  function automatic int unsigned percent_of(input int unsigned mv);
    int unsigned v;
    v = mv;
    if (span_hi_mv <= span_lo_mv) return 0;
    if (v < span_lo_mv) v = span_lo_mv;
    if (v > span_hi_mv) v = span_hi_mv;
    return ((v - span_lo_mv) * 100) / (span_hi_mv - span_lo_mv);
  endfunction

  function automatic gauge_reading_t fold_sample(input logic [SAMPLE_W-1:0] s);
    gauge_reading_t r;
    int unsigned    avg;
    int unsigned    mv;
    int unsigned    pct;
    if (!primed) begin
      // The first sample after reset stands for the whole window.
      for (int i = 0; i < WINDOW; i++) window_samples[i] = s;
      window_sum = TOTAL_W'(s * WINDOW);
      next_slot  = 1 % WINDOW;
      primed     = 1'b1;
    end else begin
      window_sum = window_sum - window_samples[next_slot] + s;
      window_samples[next_slot] = s;
      next_slot = (next_slot + 1) % WINDOW;
    end

    avg = (window_sum / WINDOW) & 32'hFFF;
    mv  = (avg * MV_FULL) / ADC_FULL;
    pct = percent_of(mv);

    case (debounce_phase)
      PH_PUBLISH: begin
        shown_percent  = PCT_W'(pct);
        debounce_phase = PH_STEADY;
      end
      PH_STEADY: begin
        if (shown_percent != PCT_W'(pct)) begin
          differ_items   = '0;
          debounce_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (differ_items != '1) differ_items = differ_items + 1'b1;
        if (differ_items >= hold_items) debounce_phase = PH_ADOPT;
        // Returning to the shown value cancels the count, even at the hold.
        if (shown_percent == PCT_W'(pct)) debounce_phase = PH_STEADY;
      end
      default: begin
        shown_percent  = PCT_W'(pct);
        debounce_phase = PH_STEADY;
      end
    endcase

    r.average_raw   = SAMPLE_W'(avg);
    r.voltage_mv    = MV_W'(mv);
    r.level_percent = shown_percent;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    fail_count++;
    $display("[%0t] result %0d, %s: expected %0d, got %0d",
             $realtime, results_checked, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    gauge_reading_t want;
    gauge_reading_t got;
    if (rst) begin
      span_lo_mv     = MIN_MV_RST;
      span_hi_mv     = MAX_MV_RST;
      hold_items     = HOLD_RST;
      for (int i = 0; i < WINDOW; i++) window_samples[i] = '0;
      next_slot      = 0;
      window_sum     = '0;
      primed         = 1'b0;
      debounce_phase = PH_PUBLISH;
      differ_items   = '0;
      shown_percent  = '0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_MV: span_lo_mv = cfg_data;
          REG_MAX_MV: span_hi_mv = cfg_data;
          REG_HOLD:   hold_items = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(fold_sample(s_axis_tdata[SAMPLE_W-1:0]));

      if (m_axis_tvalid && m_axis_tready) begin
        got.average_raw   = m_axis_tdata[11:0];
        got.voltage_mv    = m_axis_tdata[24:12];
        got.level_percent = m_axis_tdata[31:25];
        if (expected_readings.size() == 0) begin
          report_mismatch("beat with no sample outstanding", 0, m_axis_tdata);
        end else begin
          want = expected_readings.pop_front();
          if (got.average_raw != want.average_raw)
            report_mismatch("average_raw", want.average_raw, got.average_raw);
          if (got.voltage_mv != want.voltage_mv)
            report_mismatch("voltage_mv", want.voltage_mv, got.voltage_mv);
          if (got.level_percent != want.level_percent)
            report_mismatch("level_percent", want.level_percent, got.level_percent);
        end
        results_checked++;
      end
    end
    results_pending = expected_readings.size();
  end

endmodule

/* test/battery_level_debounced_gauge_tb.sv */
`timescale 1ns / 1ps
// Top of the battery level gauge testbench: clock, reset, sample and register stimulus.
// Instantiates the gauge and its scoreboard; needs bldg_pkg and the gauge RTL.
module battery_level_debounced_gauge_tb;
  import bldg_pkg::*;

  localparam int unsigned WINDOW        = 10;
  localparam int unsigned CYCLE_LIMIT   = 600_000;
  localparam int unsigned LONG_STALL    = 400;
  localparam int unsigned SETTLE_CYCLES = 150;
  // An index past the register list; writes to it must change nothing.
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index     = '0;
  logic [MV_W-1:0]   cfg_data      = '0;

  int fail_count;
  int results_checked;
  int results_pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;
  int walk_level    = 2000;
  int samples_sent  = 0;
  int reg_writes    = 0;

  battery_level_debounced_gauge #(
    .WINDOW (WINDOW)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  battery_level_debounced_gauge_checker #(
    .WINDOW (WINDOW)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .results_pending (results_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clip_sample(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  task automatic put_sample(input int s);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(s[SAMPLE_W-1:0]);
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= MV_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // Stops offering samples and waits until every outstanding result has arrived.
  task automatic settle_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (results_pending == 0);
  endtask

  task automatic random_config();
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned hold;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      lo = $urandom_range(2600, 3600);
      hi = lo + $urandom_range(100, 1500);
    end else if (pick == 6) begin
      lo = 0;
      hi = 6600;
    end else if (pick == 7) begin
      lo = $urandom_range(0, 8191);
      hi = $urandom_range(0, 8191);
    end else if (pick == 8) begin
      lo = $urandom_range(0, 6600);
      hi = lo;
    end else begin
      lo = $urandom_range(0, 3000);
      hi = $urandom_range(6600, 8191);
    end
    write_reg(REG_MIN_MV, lo);
    write_reg(REG_MAX_MV, hi);

    pick = $urandom_range(0, 9);
    if (pick < 7)       hold = $urandom_range(1, 12);
    else if (pick == 7) hold = 255;
    else if (pick == 8) hold = 0;
    else                hold = $urandom_range(0, 255);
    // Upper data bits are junk; only the low byte should reach the hold register.
    write_reg(REG_HOLD, ($urandom_range(0, 31) << 8) | hold);
  endtask

  // A slowly drifting battery level with ADC noise, plus the odd jump and wild reading.
  task automatic stream_samples(input int count);
    int s;
    walk_level = $urandom_range(1500, 3000);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 29) == 0)
        walk_level = $urandom_range(0, 4095);
      else
        walk_level = clip_sample(walk_level + int'($urandom_range(0, 6)) - 3);
      if ($urandom_range(0, 11) == 0)
        s = $urandom_range(0, 4095);
      else
        s = clip_sample(walk_level + int'($urandom_range(0, 8)) - 4);
      put_sample(s);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: the first sample fills the window and is published at once.
    put_sample(4095);
    put_sample(0);
    put_sample(4095);
    put_sample(2048);
    settle_results();

    // Zero hold, with junk above the low byte: only the low byte sets the hold, and a differing level starts the count.
    write_reg(REG_HOLD, 13'h1F00);
    put_sample(0);
    put_sample(0);
    put_sample(0);
    settle_results();

    // Empty span, then an inverted one: percent is zero.
    write_reg(REG_MIN_MV, 5000);
    write_reg(REG_MAX_MV, 5000);
    put_sample(3000);
    put_sample(1000);
    settle_results();
    write_reg(REG_MIN_MV, 6600);
    write_reg(REG_MAX_MV, 0);
    put_sample(4095);
    settle_results();

    // Registers above the millivolt range.
    write_reg(REG_MIN_MV, 0);
    write_reg(REG_MAX_MV, 13'h1FFF);
    put_sample(4095);
    put_sample(2000);
    settle_results();
    write_reg(REG_MIN_MV, 7000);
    write_reg(REG_MAX_MV, 8000);
    put_sample(4095);
    settle_results();

    // The unused index is ignored; then a short hold that a brief excursion cannot beat.
    write_reg(REG_UNUSED, 13'h1FFF);
    write_reg(REG_HOLD, 2);
    write_reg(REG_MIN_MV, MIN_MV_RST);
    write_reg(REG_MAX_MV, MAX_MV_RST);
    put_sample(2200);
    put_sample(2200);
    put_sample(2300);
    put_sample(2200);
    put_sample(2200);
    put_sample(2200);
    put_sample(1900);
    put_sample(2200);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        settle_results();
        random_config();
        // Hold the result side off while samples keep coming, so the input backs up.
        if (mode == 0 && seg == 2) stall_left = LONG_STALL;
        stream_samples(62);
      end
    end

    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples and made %0d register writes; %0d results checked.",
             samples_sent, reg_writes, results_checked);
    $display("Covered span and hold edge cases, three back-pressure mixes and a %0d-cycle stall.",
             LONG_STALL);
    if (fail_count == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/bldg_pkg.sv
sv/bldg_div.sv
sv/bldg_dp.sv
sv/bldg_ctrl.sv
sv/battery_level_debounced_gauge.sv
test/battery_level_debounced_gauge_checker.sv
test/battery_level_debounced_gauge_tb.sv
